[hdl/nodem_pkg.sv]
package nodem_pkg;

  localparam int InputWidth  = 8;
  localparam int HiddenWidth = 32;

  localparam int W1Base   = 0;
  localparam int B1Base   = W1Base + InputWidth * HiddenWidth;
  localparam int W2Base   = B1Base + HiddenWidth;
  localparam int B2Base   = W2Base + HiddenWidth * HiddenWidth;
  localparam int WoBase   = B2Base + HiddenWidth;
  localparam int ParamEnd = WoBase + HiddenWidth;

  localparam int InBits  = $clog2(InputWidth);
  localparam int HidBits = $clog2(HiddenWidth);
  localparam int W1Bits  = $clog2(InputWidth * HiddenWidth);
  localparam int W2Bits  = $clog2(HiddenWidth * HiddenWidth);
  localparam int AccBits = 56;

  // Input transaction kinds
  localparam logic OpLoad    = 1'b0;
  localparam logic OpFeature = 1'b1;

  typedef logic signed [31:0] word_t;
  typedef logic signed [AccBits-1:0] acc_t;

  // Phase selects which weight store feeds the multiplier.
  typedef enum logic [1:0] {
    PH_L1  = 2'd0,
    PH_L2  = 2'd1,
    PH_OUT = 2'd2
  } phase_t;

  // Controller to datapath command group.
  typedef struct packed {
    logic          issue;     // a product enters the pipe this cycle
    phase_t        phase;
    logic [HidBits-1:0] col;  // output neuron j
    logic [HidBits-1:0] row;  // input term i
    logic          first;     // first term of a sum
    logic          last;      // last term of a sum
  } dp_cmd_t;

  typedef struct packed {
    logic busy;               // sums still in flight
  } dp_sts_t;

  function automatic word_t sat32(input acc_t v);
    if (v > acc_t'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < -acc_t'(33'sh080000000)) return 32'sh80000000;
    return word_t'(v[31:0]);
  endfunction

  function automatic logic [16:0] tanh_lut(input logic [4:0] k);
    unique case (k)
      5'd0:  tanh_lut = 17'd0;
      5'd1:  tanh_lut = 17'd16051;
      5'd2:  tanh_lut = 17'd30285;
      5'd3:  tanh_lut = 17'd41625;
      5'd4:  tanh_lut = 17'd49912;
      5'd5:  tanh_lut = 17'd55593;
      5'd6:  tanh_lut = 17'd59320;
      5'd7:  tanh_lut = 17'd61694;
      5'd8:  tanh_lut = 17'd63179;
      5'd9:  tanh_lut = 17'd64096;
      5'd10: tanh_lut = 17'd64659;
      5'd11: tanh_lut = 17'd65003;
      5'd12: tanh_lut = 17'd65212;
      5'd13: tanh_lut = 17'd65339;
      5'd14: tanh_lut = 17'd65417;
      5'd15: tanh_lut = 17'd65464;
      default: tanh_lut = 17'd65492;
    endcase
  endfunction

  // Piecewise linear tanh with saturation at 4.0.
  function automatic word_t tanh_q(input word_t v);
    logic [32:0] a;
    logic [18:0] ac;
    logic [4:0]  k;
    logic [13:0] f;
    logic [16:0] t0;
    logic [16:0] t1;
    logic [31:0] prod;
    logic [16:0] r;
    a  = v[31] ? 33'(-{v[31], v}) : {1'b0, v};
    ac = (a > 33'h40000) ? 19'h40000 : a[18:0];
    k  = ac[18:14];
    f  = ac[13:0];
    t0 = tanh_lut(k);
    t1 = tanh_lut(5'(k + 5'd1));
    prod = 32'(t1 - t0) * 32'(f);
    r = (k >= 5'd16) ? tanh_lut(5'd16) : 17'(t0 + 17'(prod >> 14));
    return v[31] ? -word_t'({15'd0, r}) : word_t'({15'd0, r});
  endfunction

endpackage

[hdl/neural_ode_euler_mlp_inference.sv]
// Neural-ODE inference engine (Q16.16, one residual Euler step).
// Input channel (in_valid/in_stall): op=0 writes param_value at flat
// param_index into the W1, b1, W2, b2 or output-weight store; addresses past
// the layout are dropped. op=1 delivers one feature; the eighth feature of a
// sample starts the network.
// Output channel (out_valid/out_stall): one prediction per sample.
// Loads and the first seven features are taken while the engine is idle. A
// sample runs on one shared multiply-accumulate pipe: 256 + 1024 + 32 terms,
// one per cycle, plus pipe drain between layers. in_stall is high while the
// network runs.
// The prediction sits in an output register; the next sample may load and
// start while it waits, but its finish holds until the receiver takes it.
// Reset clears the feature count and the control; weights are undefined
// until written.
module neural_ode_euler_mlp_inference (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    op,
  input  logic [10:0]             param_index,
  input  logic signed [31:0]      param_value,
  input  logic signed [31:0]      feature,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [31:0]      prediction
);
  import nodem_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    start, done, idle, acc_in;
  logic [InBits:0] fcount;
  word_t   res;

  assign in_stall = !idle;
  assign acc_in   = in_valid && !in_stall;
  assign start    = acc_in && (op == OpFeature) &&
                    (fcount == (InBits+1)'(InputWidth - 1));

  // Count features of the current sample
  always_ff @(posedge clk) begin
    if (rst) fcount <= '0;
    else if (acc_in && op == OpFeature) fcount <= start ? '0 : fcount + 1'b1;
  end

  nodem_ctrl u_ctrl (
    .clk, .rst, .start, .sts, .out_free(!out_valid || !out_stall),
    .cmd, .done, .idle);

  nodem_dp u_dp (
    .clk, .rst,
    .pw_en(acc_in && op == OpLoad), .pw_addr(param_index), .pw_data(param_value),
    .fw_en(acc_in && op == OpFeature), .fw_addr(fcount[InBits-1:0]), .fw_data(feature),
    .cmd, .sts, .result(res));

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (done) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (done) prediction <= res;
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> idle) else $error("sample started while busy");
  a_start_leaves: assert property (@(posedge clk) disable iff (rst)
    start |=> !idle) else $error("controller ignored start");
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |-> (!out_valid || !out_stall)) else $error("result overwritten");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    fcount < (InBits+1)'(InputWidth)) else $error("feature count overflow");
endmodule

[hdl/nodem_ram.sv]
module nodem_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[hdl/nodem_ctrl.sv]
module nodem_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  nodem_pkg::dp_sts_t sts,
  input  logic               out_free,
  output nodem_pkg::dp_cmd_t cmd,
  output logic               done,
  output logic               idle
);
  import nodem_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_L1    = 5'b00010,
    S_L2    = 5'b00100,
    S_OUT   = 5'b01000,
    S_DRAIN = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [HidBits-1:0] col, col_next;
  logic [HidBits-1:0] row, row_next;
  logic [HidBits-1:0] row_end;

  always_comb begin
    unique case (state)
      S_L1:    row_end = HidBits'(InputWidth - 1);
      default: row_end = HidBits'(HiddenWidth - 1);
    endcase
  end

  // Walk rows then columns; wait for each layer to drain before the next
  always_comb begin
    state_next = state;
    col_next   = col;
    row_next   = row;
    cmd        = '0;
    done       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_L1;
          col_next   = '0;
          row_next   = '0;
        end
      end
      S_L1, S_L2, S_OUT: begin
        if (!sts.busy || state != S_L2 || row != '0 || col != '0) begin
          cmd.issue = 1'b1;
          unique case (state)
            S_L1:    cmd.phase = PH_L1;
            S_L2:    cmd.phase = PH_L2;
            default: cmd.phase = PH_OUT;
          endcase
          cmd.col   = col;
          cmd.row   = row;
          cmd.first = (row == '0) && (state != S_OUT || col == '0);
          // The output layer is one sum over all columns
          cmd.last  = (state == S_OUT) ? (col == HidBits'(HiddenWidth - 1))
                                       : (row == row_end);
          if (state == S_OUT) begin
            col_next = col + 1'b1;
            if (col == HidBits'(HiddenWidth - 1)) state_next = S_DRAIN;
          end else if (row == row_end) begin
            row_next = '0;
            col_next = col + 1'b1;
            if (col == HidBits'(HiddenWidth - 1)) begin
              col_next   = '0;
              state_next = (state == S_L1) ? S_L2 : S_OUT;
            end
          end else begin
            row_next = row + 1'b1;
          end
        end
      end
      default: begin
        if (!sts.busy && out_free) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
    // Output layer reads the updated hidden vector; hold until L2 drains
    if (state == S_OUT && col == '0 && sts.busy) begin
      cmd.issue  = 1'b0;
      col_next   = col;
      state_next = state;
    end
  end

  assign idle = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      col   <= '0;
      row   <= '0;
    end else begin
      state <= state_next;
      col   <= col_next;
      row   <= row_next;
    end
  end
endmodule

[hdl/nodem_dp.sv]
module nodem_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               pw_en,
  input  logic [10:0]        pw_addr,
  input  nodem_pkg::word_t   pw_data,
  input  logic               fw_en,
  input  logic [nodem_pkg::InBits-1:0] fw_addr,
  input  nodem_pkg::word_t   fw_data,
  input  nodem_pkg::dp_cmd_t cmd,
  output nodem_pkg::dp_sts_t sts,
  output nodem_pkg::word_t   result
);
  import nodem_pkg::*;

  // Decode parameter writes
  logic        we_w1, we_b1, we_w2, we_b2, we_wo;
  logic [10:0] off;
  always_comb begin
    we_w1 = 1'b0; we_b1 = 1'b0; we_w2 = 1'b0; we_b2 = 1'b0; we_wo = 1'b0;
    off   = pw_addr;
    priority if (pw_addr < 11'(B1Base)) begin
      we_w1 = pw_en; off = pw_addr - 11'(W1Base);
    end else if (pw_addr < 11'(W2Base)) begin
      we_b1 = pw_en; off = pw_addr - 11'(B1Base);
    end else if (pw_addr < 11'(B2Base)) begin
      we_w2 = pw_en; off = pw_addr - 11'(W2Base);
    end else if (pw_addr < 11'(WoBase)) begin
      we_b2 = pw_en; off = pw_addr - 11'(B2Base);
    end else if (pw_addr < 11'(ParamEnd)) begin
      we_wo = pw_en; off = pw_addr - 11'(WoBase);
    end else begin
      // Drop writes past the layout
      off = '0;
    end
  end

  // Stage 0: read addresses
  logic [W1Bits-1:0] ra_w1;
  logic [W2Bits-1:0] ra_w2;
  logic [HidBits-1:0] ra_h;
  word_t rd_w1, rd_b1, rd_w2, rd_b2, rd_wo, rd_x, rd_h, rd_r;

  always_comb begin
    ra_w1 = W1Bits'(cmd.row) * W1Bits'(HiddenWidth) + W1Bits'(cmd.col);
    ra_w2 = W2Bits'(cmd.row) * W2Bits'(HiddenWidth) + W2Bits'(cmd.col);
    ra_h  = (cmd.phase == PH_OUT) ? cmd.col : cmd.row;
  end

  nodem_ram #(.Width(32), .Depth(InputWidth*HiddenWidth)) u_w1 (
    .clk, .we(we_w1), .waddr(off[W1Bits-1:0]), .wdata(pw_data),
    .raddr(ra_w1), .rdata(rd_w1));
  nodem_ram #(.Width(32), .Depth(HiddenWidth)) u_b1 (
    .clk, .we(we_b1), .waddr(off[HidBits-1:0]), .wdata(pw_data),
    .raddr(cmd.col), .rdata(rd_b1));
  nodem_ram #(.Width(32), .Depth(HiddenWidth*HiddenWidth)) u_w2 (
    .clk, .we(we_w2), .waddr(off[W2Bits-1:0]), .wdata(pw_data),
    .raddr(ra_w2), .rdata(rd_w2));
  nodem_ram #(.Width(32), .Depth(HiddenWidth)) u_b2 (
    .clk, .we(we_b2), .waddr(off[HidBits-1:0]), .wdata(pw_data),
    .raddr(cmd.col), .rdata(rd_b2));
  nodem_ram #(.Width(32), .Depth(HiddenWidth)) u_wo (
    .clk, .we(we_wo), .waddr(off[HidBits-1:0]), .wdata(pw_data),
    .raddr(cmd.col), .rdata(rd_wo));
  nodem_ram #(.Width(32), .Depth(InputWidth)) u_x (
    .clk, .we(fw_en), .waddr(fw_addr), .wdata(fw_data),
    .raddr(cmd.row[InBits-1:0]), .rdata(rd_x));

  // Hidden vector: written by the first layer, read at one address
  logic               hw_en;
  logic [HidBits-1:0] hw_addr;
  word_t              hw_data;
  nodem_ram #(.Width(32), .Depth(HiddenWidth)) u_h (
    .clk, .we(hw_en), .waddr(hw_addr), .wdata(hw_data),
    .raddr(ra_h), .rdata(rd_h));

  // Residual vector: written by the Euler step, read by the output layer
  logic  rw_en;
  word_t rw_data;
  nodem_ram #(.Width(32), .Depth(HiddenWidth)) u_r (
    .clk, .we(rw_en), .waddr(hw_addr), .wdata(rw_data),
    .raddr(cmd.col), .rdata(rd_r));

  // Stage 1: memories output; select operands
  logic               v1, first1, last1;
  phase_t             ph1;
  logic [HidBits-1:0] col1;
  logic [HidBits-1:0] row1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= cmd.issue;
    ph1 <= cmd.phase; col1 <= cmd.col; row1 <= cmd.row;
    first1 <= cmd.first; last1 <= cmd.last;
  end

  word_t opa, opb, bias1;
  always_comb begin
    unique case (ph1)
      PH_L1:   begin opa = rd_x; opb = rd_w1; bias1 = rd_b1; end
      PH_L2:   begin opa = rd_h; opb = rd_w2; bias1 = rd_b2; end
      default: begin opa = rd_r; opb = rd_wo; bias1 = '0;    end
    endcase
  end

  // Stage 2: product register; keep h[j] from the term whose row equals the column
  logic               v2, first2, last2;
  phase_t             ph2;
  logic [HidBits-1:0] col2;
  logic signed [63:0] prod2;
  word_t              bias2, hold2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    ph2 <= ph1; col2 <= col1; first2 <= first1; last2 <= last1;
    prod2 <= opa * opb;
    bias2 <= bias1;
    if (v1 && row1 == col1) hold2 <= rd_h;
  end

  // Stage 3: accumulate floor-shifted products
  acc_t acc, acc_next;
  logic v3;
  phase_t ph3;
  logic [HidBits-1:0] col3;
  word_t hold3;
  always_comb begin
    acc_next = (first2 ? acc_t'(bias2) : acc) + acc_t'(prod2 >>> 16);
  end
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2 && last2;
    if (v2) acc <= acc_next;
    ph3 <= ph2; col3 <= col2; hold3 <= hold2;
  end

  // Stage 4: saturate, tanh, residual and write back
  word_t s3, t3;
  always_comb begin
    s3 = sat32(acc);
    t3 = tanh_q(s3);
    hw_en   = v3 && (ph3 == PH_L1);
    hw_addr = col3;
    hw_data = s3;
    rw_en   = v3 && (ph3 == PH_L2);
    rw_data = sat32(acc_t'(hold3) + acc_t'(t3));
  end
  always_ff @(posedge clk) begin
    if (v3 && ph3 == PH_OUT) result <= s3;
  end

  assign sts.busy = v1 | v2 | v3;
endmodule
